### src/lap_stopwatch_assert.svh
// Assertion macros shared by the stopwatch checker.
// Needs nothing else; each macro expands to one labeled concurrent assertion.
`ifndef LAP_STOPWATCH_ASSERT_SVH
`define LAP_STOPWATCH_ASSERT_SVH

// Antecedent and consequent hold in the same cycle.
`define LSW_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define LSW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/lsw_pkg.sv
// Shared types and constants of the lap stopwatch: mode and command codes,
// the minute cap and the constant-divisor reciprocals of the readout. No dependencies.
package lsw_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_RUN   = 2'd1,
    MODE_PAUSE = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    CMD_READ   = 2'd0,
    CMD_TOGGLE = 2'd1,
    CMD_LAP    = 2'd2
  } cmd_e;

  // The readout is pinned once whole minutes exceed this value (at most 99).
  localparam int unsigned MINUTE_CAP = 99;
  localparam logic [31:0] CAP_LIMIT_MS = 32'((MINUTE_CAP + 1) * 60000);
  localparam logic [6:0]  CAP_MINUTES  = 7'(MINUTE_CAP);
  localparam logic [5:0]  CAP_SECONDS  = 6'd59;
  localparam logic [6:0]  CAP_CENTIS   = 7'd99;

  // Below the cap the elapsed time fits in DIG_W bits.
  localparam int unsigned DIG_W = 23;
  localparam int unsigned SEC_W = 14;
  localparam int unsigned MIN_W = 9;
  localparam int unsigned MS_W  = 10;

  localparam logic [9:0] MS_PER_S  = 10'd1000;
  localparam logic [5:0] S_PER_MIN = 6'd60;

  // Rounded-up reciprocals; each gives the exact quotient over its input width.
  localparam logic [23:0] SEC_RECIP = 24'd8589935;  // x / 1000, x < 2^23
  localparam int unsigned SEC_SHIFT = 33;
  localparam int unsigned SEC_PROD_W = DIG_W + 24;
  localparam logic [14:0] MIN_RECIP = 15'd17477;    // x / 60, x < 2^14
  localparam int unsigned MIN_SHIFT = 20;
  localparam int unsigned MIN_PROD_W = SEC_W + 15;
  localparam logic [10:0] CS_RECIP  = 11'd1639;     // x / 10, x < 2^10
  localparam int unsigned CS_SHIFT  = 14;
  localparam int unsigned CS_PROD_W = MS_W + 11;

endpackage

### src/lap_stopwatch.sv
// Lap stopwatch top level; depends on lsw_pkg.
//
// Input channel (in_valid_i / in_stall_o) carries one word per command:
// cmd_i, the current millisecond timestamp now_ms_i and the lap slot to
// report, lap_index_i. Output channel (out_valid_o / out_stall_i) returns
// exactly one word per accepted input word, in order: mode, elapsed time,
// its min:sec.centi readout (pinned at the cap with capped_o) and one lap.
//
// Throughput is one word per clock while the output is not stalled. The
// mode and time registers and the lap memory are updated in the cycle a
// word is accepted; the lap memory is a ring with one write and one
// registered read port, and a read of the entry written in the same cycle
// is forwarded. A result is registered in order through the memory read,
// the seconds reciprocal, minutes and milliseconds, then the final digits
// into the output register.
//
// Reset puts the watch in idle with no laps; lap memory contents are not
// cleared, since entries beyond the lap count never reach the output.
// When the receiver stalls, the output word holds; stages behind it keep
// filling bubbles, so the sender is stalled only when the pipeline is full.
module lap_stopwatch import lsw_pkg::*; #(
  parameter int unsigned LAP_SLOTS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [31:0] now_ms_i,
  input  logic [1:0]  lap_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  run_mode_o,
  output logic [31:0] elapsed_ms_o,
  output logic [6:0]  minutes_o,
  output logic [5:0]  seconds_o,
  output logic [6:0]  centiseconds_o,
  output logic        capped_o,
  output logic        lap_valid_o,
  output logic [31:0] lap_number_o,
  output logic [31:0] lap_split_ms_o,
  output logic [31:0] lap_total_ms_o,
  output logic [2:0]  laps_held_o
);

  localparam int unsigned AW    = (LAP_SLOTS > 1) ? $clog2(LAP_SLOTS) : 1;
  localparam int unsigned DEPTH = 2 ** AW;
  localparam int unsigned HW    = $clog2(LAP_SLOTS + 1);

  typedef struct packed {
    logic [31:0] split;
    logic [31:0] total;
  } lap_t;

  typedef struct packed {
    mode_e          mode;
    logic [31:0]    el;
    logic [HW-1:0]  held;
    logic [31:0]    laps;
    logic [1:0]     idx;
    logic           fwd;
    lap_t           fwd_lap;
  } s1_t;

  typedef struct packed {
    mode_e            mode;
    logic [31:0]      el;
    logic             capped;
    logic [HW-1:0]    held;
    logic             lap_valid;
    logic [31:0]      lap_num;
    lap_t             lap;
    logic [DIG_W-1:0] x;
    logic [SEC_W-1:0] qs;
  } s2_t;

  typedef struct packed {
    mode_e            mode;
    logic [31:0]      el;
    logic             capped;
    logic [HW-1:0]    held;
    logic             lap_valid;
    logic [31:0]      lap_num;
    lap_t             lap;
    logic [MS_W-1:0]  ms;
    logic [SEC_W-1:0] qs;
    logic [MIN_W-1:0] mm;
  } s3_t;

  typedef struct packed {
    mode_e          mode;
    logic [31:0]    el;
    logic [6:0]     minutes;
    logic [5:0]     seconds;
    logic [6:0]     centis;
    logic           capped;
    logic           lap_valid;
    logic [31:0]    lap_num;
    lap_t           lap;
    logic [HW-1:0]  held;
  } out_t;

  // Pipeline flow control: a stage loads when it is empty or moves on.
  logic v1_q, v2_q, v3_q, vo_q;
  logic adv1, adv2, adv3, adv_o, in_fire;

  assign adv_o      = !vo_q || !out_stall_i;
  assign adv3       = !v3_q || adv_o;
  assign adv2       = !v2_q || adv3;
  assign adv1       = !v1_q || adv2;
  assign in_stall_o = !adv1;
  assign in_fire    = in_valid_i && adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (adv1)  v1_q <= in_valid_i;
      if (adv2)  v2_q <= v1_q;
      if (adv3)  v3_q <= v2_q;
      if (adv_o) vo_q <= v3_q;
    end
  end

  // Watch state. The run offset holds base - run_start, so the running
  // elapsed time is a single add onto the timestamp.
  mode_e          mode_q, mode_d;
  logic [31:0]    base_q, base_d;
  logic [31:0]    off_q, off_d;
  logic [31:0]    mark_q, mark_d;
  logic [31:0]    laps_q, laps_d;
  logic [HW-1:0]  held_q, held_d;
  logic [AW-1:0]  wp_q, wp_d;

  logic [31:0]    e_old;
  logic [31:0]    el0;
  logic           push;
  lap_t           new_lap;
  logic [AW+2:0]  addr_wide;
  logic [AW-1:0]  rd_addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      base_q <= '0;
      off_q  <= '0;
      mark_q <= '0;
      laps_q <= '0;
      held_q <= '0;
      wp_q   <= '0;
    end else begin
      mode_q <= mode_d;
      base_q <= base_d;
      off_q  <= off_d;
      mark_q <= mark_d;
      laps_q <= laps_d;
      held_q <= held_d;
      wp_q   <= wp_d;
    end
  end

  always_comb begin
    e_old         = now_ms_i + off_q;
    new_lap.total = e_old;
    new_lap.split = e_old - mark_q;
    mode_d        = mode_q;
    base_d        = base_q;
    off_d         = off_q;
    mark_d        = mark_q;
    laps_d        = laps_q;
    held_d        = held_q;
    wp_d          = wp_q;
    push          = 1'b0;
    el0           = (mode_q == MODE_RUN) ? e_old : base_q;
    if (in_fire) begin
      unique case (cmd_e'(cmd_i))
        CMD_TOGGLE: begin
          if (mode_q == MODE_RUN) begin
            base_d = e_old;
            mode_d = MODE_PAUSE;
          end else begin
            off_d  = base_q - now_ms_i;
            mode_d = MODE_RUN;
            el0    = base_q;
          end
        end
        CMD_LAP: begin
          unique case (mode_q)
            MODE_RUN: begin
              push   = 1'b1;
              mark_d = e_old;
              laps_d = laps_q + 32'd1;
              wp_d   = wp_q + AW'(1);
              if (held_q < HW'(LAP_SLOTS)) begin
                held_d = held_q + HW'(1);
              end
            end
            MODE_PAUSE: begin
              mode_d = MODE_IDLE;
              base_d = '0;
              off_d  = '0;
              mark_d = '0;
              laps_d = '0;
              held_d = '0;
              wp_d   = '0;
              el0    = '0;
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
    // Slot k sits k entries behind the newest, which is just below the
    // write pointer after this command.
    addr_wide = {3'b000, wp_d} - (AW + 3)'(1) - {{(AW + 1){1'b0}}, lap_index_i};
    rd_addr   = addr_wide[AW-1:0];
  end

  // Lap ring memory: one write, one registered read.
  lap_t lap_mem [DEPTH];
  lap_t rd_lap_q;

  always_ff @(posedge clk_i) begin
    if (push) begin
      lap_mem[wp_q] <= new_lap;
    end
    if (adv1) begin
      rd_lap_q <= lap_mem[rd_addr];
    end
  end

  s1_t s1_q, s1_d;
  s2_t s2_q, s2_d;
  s3_t s3_q, s3_d;
  out_t out_q, out_d;

  always_comb begin
    s1_d.mode    = mode_d;
    s1_d.el      = el0;
    s1_d.held    = held_d;
    s1_d.laps    = laps_d;
    s1_d.idx     = lap_index_i;
    s1_d.fwd     = push && (rd_addr == wp_q);
    s1_d.fwd_lap = new_lap;
  end

  // Stage 1: resolve the lap entry, cap test and the seconds quotient.
  lap_t                  lap_sel;
  logic [SEC_PROD_W-1:0] prod_s;

  always_comb begin
    lap_sel        = s1_q.fwd ? s1_q.fwd_lap : rd_lap_q;
    s2_d.mode      = s1_q.mode;
    s2_d.el        = s1_q.el;
    s2_d.held      = s1_q.held;
    s2_d.capped    = s1_q.el >= CAP_LIMIT_MS;
    s2_d.lap_valid = {{HW{1'b0}}, s1_q.idx} < {2'b00, s1_q.held};
    s2_d.lap_num   = s2_d.lap_valid ? (s1_q.laps - {30'd0, s1_q.idx}) : '0;
    s2_d.lap       = s2_d.lap_valid ? lap_sel : '0;
    s2_d.x         = s1_q.el[DIG_W-1:0];
    prod_s         = s2_d.x * SEC_RECIP;
    s2_d.qs        = prod_s[SEC_SHIFT +: SEC_W];
  end

  // Stage 2: milliseconds within the second and whole minutes.
  logic [DIG_W-1:0]      qs_ms;
  logic [DIG_W-1:0]      ms_wide;
  logic [MIN_PROD_W-1:0] prod_m;

  always_comb begin
    qs_ms          = {{(DIG_W - SEC_W){1'b0}}, s2_q.qs} * DIG_W'(MS_PER_S);
    ms_wide        = s2_q.x - qs_ms;
    prod_m         = s2_q.qs * MIN_RECIP;
    s3_d.mode      = s2_q.mode;
    s3_d.el        = s2_q.el;
    s3_d.capped    = s2_q.capped;
    s3_d.held      = s2_q.held;
    s3_d.lap_valid = s2_q.lap_valid;
    s3_d.lap_num   = s2_q.lap_num;
    s3_d.lap       = s2_q.lap;
    s3_d.ms        = ms_wide[MS_W-1:0];
    s3_d.qs        = s2_q.qs;
    s3_d.mm        = prod_m[MIN_SHIFT +: MIN_W];
  end

  // Stage 3: seconds within the minute, centiseconds and the cap pin.
  logic [SEC_W-1:0]     ss_wide;
  logic [CS_PROD_W-1:0] prod_c;

  always_comb begin
    ss_wide         = s3_q.qs - ({{(SEC_W - MIN_W){1'b0}}, s3_q.mm} * SEC_W'(S_PER_MIN));
    prod_c          = s3_q.ms * CS_RECIP;
    out_d.mode      = s3_q.mode;
    out_d.el        = s3_q.el;
    out_d.capped    = s3_q.capped;
    out_d.lap_valid = s3_q.lap_valid;
    out_d.lap_num   = s3_q.lap_num;
    out_d.lap       = s3_q.lap;
    out_d.held      = s3_q.held;
    if (s3_q.capped) begin
      out_d.minutes = CAP_MINUTES;
      out_d.seconds = CAP_SECONDS;
      out_d.centis  = CAP_CENTIS;
    end else begin
      out_d.minutes = s3_q.mm[6:0];
      out_d.seconds = ss_wide[5:0];
      out_d.centis  = prod_c[CS_SHIFT +: 7];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1)  s1_q  <= s1_d;
    if (adv2)  s2_q  <= s2_d;
    if (adv3)  s3_q  <= s3_d;
    if (adv_o) out_q <= out_d;
  end

  logic [HW+2:0] held_ext;

  assign held_ext       = {3'b000, out_q.held};
  assign out_valid_o    = vo_q;
  assign run_mode_o     = out_q.mode;
  assign elapsed_ms_o   = out_q.el;
  assign minutes_o      = out_q.minutes;
  assign seconds_o      = out_q.seconds;
  assign centiseconds_o = out_q.centis;
  assign capped_o       = out_q.capped;
  assign lap_valid_o    = out_q.lap_valid;
  assign lap_number_o   = out_q.lap_num;
  assign lap_split_ms_o = out_q.lap.split;
  assign lap_total_ms_o = out_q.lap.total;
  assign laps_held_o    = held_ext[2:0];

endmodule

### src/lsw_checker.sv
// Port-level checker for the lap stopwatch, bound to the top level below.
// Depends on lsw_pkg and the assertion macros in lap_stopwatch_assert.svh.
`include "lap_stopwatch_assert.svh"

module lsw_checker import lsw_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  run_mode_o,
  input logic [31:0] elapsed_ms_o,
  input logic [6:0]  minutes_o,
  input logic [5:0]  seconds_o,
  input logic [6:0]  centiseconds_o,
  input logic        capped_o,
  input logic        lap_valid_o,
  input logic [31:0] lap_total_ms_o,
  input logic [2:0]  laps_held_o
);

  // A stalled result word stays put.
  `LSW_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(run_mode_o) && $stable(elapsed_ms_o) && $stable(lap_total_ms_o), "stalled result word changed")

  // With the output free to move, the pipeline never pushes back on the sender.
  `LSW_ASSERT_IMPL(a_no_false_stall, clk_i, rst_ni, !out_valid_o || !out_stall_i, !in_stall_o, "input stalled while output can drain")

  // Idle is only reached by reset or a clear, so nothing has been timed.
  `LSW_ASSERT_IMPL(a_idle_clear, clk_i, rst_ni, out_valid_o && (run_mode_o == MODE_IDLE), (elapsed_ms_o == 32'd0) && (laps_held_o == 3'd0) && !lap_valid_o, "idle result shows time or laps")

  // A pinned readout shows the full cap value.
  `LSW_ASSERT_IMPL(a_cap_pin, clk_i, rst_ni, out_valid_o && capped_o, (minutes_o == CAP_MINUTES) && (seconds_o == CAP_SECONDS) && (centiseconds_o == CAP_CENTIS), "capped readout not pinned")

endmodule

bind lap_stopwatch lsw_checker u_lsw_checker (.*);
